/* sv/rme_pkg.sv */
// rme_pkg: types, codes and constants shared by the range motion estimator
// used by rme_serial_unit, range_motion_estimator_core and rme_checker
package rme_pkg;

    localparam int DIST_W      = 16;
    localparam int TIME_W      = 32;
    localparam int SPEED_W     = 16;
    localparam int DISP_W      = 17;
    localparam int LIM_W       = 15;
    localparam int KIND_W      = 2;
    localparam int STEP_W      = 8;
    localparam int CFG_AW      = 3;
    localparam int CFG_DW      = 16;
    localparam int OPB_W       = 16;
    localparam int PROD_W      = 31;
    localparam int QUO_W       = 26;
    localparam int CNT_W       = 5;
    localparam int MUL_STEPS   = 16;
    localparam int DIV_STEPS   = 26;
    localparam int IN_TDATA_W  = 48;
    localparam int OUT_TDATA_W = 88;

    localparam logic [KIND_W-1:0] KIND_SAMPLE  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_INVALID = 2'd1;
    localparam logic [KIND_W-1:0] KIND_STALE   = 2'd2;

    localparam logic [CFG_AW-1:0] CFG_MIN_DIST   = 3'd0;
    localparam logic [CFG_AW-1:0] CFG_MAX_DIST   = 3'd1;
    localparam logic [CFG_AW-1:0] CFG_MIN_INT    = 3'd2;
    localparam logic [CFG_AW-1:0] CFG_MAX_INT    = 3'd3;
    localparam logic [CFG_AW-1:0] CFG_STALE      = 3'd4;
    localparam logic [CFG_AW-1:0] CFG_MAX_SPEED  = 3'd5;
    localparam logic [CFG_AW-1:0] CFG_JUMP_MARG  = 3'd6;
    localparam logic [CFG_AW-1:0] CFG_SPEED_LIM  = 3'd7;

    localparam logic [DIST_W-1:0] RST_MIN_DIST  = 16'd20;
    localparam logic [DIST_W-1:0] RST_MAX_DIST  = 16'd4000;
    localparam logic [OPB_W-1:0]  RST_MIN_INT   = 16'd40;
    localparam logic [OPB_W-1:0]  RST_MAX_INT   = 16'd300;
    localparam logic [OPB_W-1:0]  RST_STALE     = 16'd350;
    localparam logic [LIM_W-1:0]  RST_MAX_SPEED = 15'd1500;
    localparam logic [LIM_W-1:0]  RST_JUMP_MARG = 15'd40;
    localparam logic [LIM_W-1:0]  RST_SPEED_LIM = 15'd2000;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EVAL,
        ST_DECIDE,
        ST_MUL,
        ST_CHECK,
        ST_DIV,
        ST_SMOOTH,
        ST_EMIT
    } t_state;

    typedef enum logic [1:0] {
        SU_IDLE,
        SU_MUL,
        SU_DIV,
        SU_DONE
    } t_su_state;

    typedef struct packed {
        logic start_mul;
        logic start_div;
    } t_su_ctrl;

    typedef struct packed {
        logic idle;
        logic done;
    } t_su_stat;

endpackage

/* sv/rme_serial_unit.sv */
// rme_serial_unit: shift-add multiplier and restoring divider, one bit per cycle
// depends on rme_pkg
module rme_serial_unit import rme_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_su_ctrl           i_ctrl,
    input  logic [LIM_W-1:0]   i_mcand,
    input  logic [QUO_W-1:0]   i_dividend,
    input  logic [OPB_W-1:0]   i_opb,
    output t_su_stat           o_stat,
    output logic [PROD_W-1:0]  o_product,
    output logic [QUO_W-1:0]   o_quotient
);

    localparam logic [CNT_W-1:0] MUL_LAST = CNT_W'(MUL_STEPS - 1);
    localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(DIV_STEPS - 1);

    t_su_state          r_state, n_state;
    logic [PROD_W-1:0]  r_acc, n_acc;
    logic [PROD_W-1:0]  r_sh, n_sh;
    logic [QUO_W-1:0]   r_q, n_q;
    logic [OPB_W-1:0]   r_rem, n_rem;
    logic [OPB_W-1:0]   r_div, n_div;
    logic [CNT_W-1:0]   r_cnt, n_cnt;

    logic [OPB_W:0]     trial;
    logic [OPB_W+1:0]   diff;

    assign trial = {r_rem, r_q[QUO_W-1]};
    assign diff  = {1'b0, trial} - {2'b00, r_div};

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            SU_IDLE: begin
                if (i_ctrl.start_mul) begin
                    n_state = SU_MUL;
                end else if (i_ctrl.start_div) begin
                    n_state = SU_DIV;
                end
            end
            SU_MUL: begin
                if (r_cnt == MUL_LAST) begin
                    n_state = SU_DONE;
                end
            end
            SU_DIV: begin
                if (r_cnt == DIV_LAST) begin
                    n_state = SU_DONE;
                end
            end
            SU_DONE: n_state = SU_IDLE;
            default: n_state = SU_IDLE;
        endcase
    end

    // status outputs
    always_comb begin
        o_stat.idle = (r_state == SU_IDLE);
        o_stat.done = (r_state == SU_DONE);
    end

    // datapath
    always_comb begin
        n_acc = r_acc;
        n_sh  = r_sh;
        n_q   = r_q;
        n_rem = r_rem;
        n_div = r_div;
        n_cnt = r_cnt;
        case (r_state)
            SU_IDLE: begin
                if (i_ctrl.start_mul) begin
                    n_acc = '0;
                    n_sh  = {{(PROD_W-LIM_W){1'b0}}, i_mcand};
                    n_q   = {{(QUO_W-OPB_W){1'b0}}, i_opb};
                    n_cnt = '0;
                end else if (i_ctrl.start_div) begin
                    n_rem = '0;
                    n_q   = i_dividend;
                    n_div = i_opb;
                    n_cnt = '0;
                end
            end
            SU_MUL: begin
                if (r_q[0]) begin
                    n_acc = r_acc + r_sh;
                end
                n_sh  = {r_sh[PROD_W-2:0], 1'b0};
                n_q   = {1'b0, r_q[QUO_W-1:1]};
                n_cnt = r_cnt + 1'b1;
            end
            SU_DIV: begin
                if (!diff[OPB_W+1]) begin
                    n_rem = diff[OPB_W-1:0];
                    n_q   = {r_q[QUO_W-2:0], 1'b1};
                end else begin
                    n_rem = trial[OPB_W-1:0];
                    n_q   = {r_q[QUO_W-2:0], 1'b0};
                end
                n_cnt = r_cnt + 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= SU_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
        r_acc <= n_acc;
        r_sh  <= n_sh;
        r_q   <= n_q;
        r_rem <= n_rem;
        r_div <= n_div;
    end

    assign o_product  = r_acc;
    assign o_quotient = r_q;

endmodule

/* sv/range_motion_estimator_core.sv */
// range_motion_estimator_core: top level of the range motion estimator
// depends on rme_pkg and rme_serial_unit
//
// Input words on s_axis carry a range sample, an invalid-sample note or a
// stale tick (tuser) with a distance and a millisecond time (tdata). Every
// input word gives exactly one output word on m_axis with the held estimate.
// Write registers through i_cfg_we / i_cfg_addr / i_cfg_wdata only while the block
// is idle; the block does not enforce this. Writes take effect on the next clock edge.
// One word is worked on at a time, from accept to the next accept. Notes, stale ticks,
// rejected samples and samples while the ring fills go from ST_EVAL to ST_EMIT; others
// pass ST_DECIDE, which sends one that is too soon or sets a new reference to ST_EMIT.
// Else ST_MUL runs the bit-serial multiply for the jump bound and ST_CHECK sends a
// jump to ST_EMIT; else ST_DIV runs a restoring divide for delta*1000/dt in the
// shared serial unit and ST_SMOOTH updates the estimate before ST_EMIT, where the
// result is loaded into an output register. While the receiver stalls, the word is
// held and the block goes on with the next input word, then waits with its result
// until the output register is free.
// Synchronous active-low reset clears the estimate, the ring fill, the state and the
// configuration registers to their reset values; s_axis_tready is high in the next cycle.
module range_motion_estimator_core import rme_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_we,
    input  logic [CFG_AW-1:0]       i_cfg_addr,
    input  logic [CFG_DW-1:0]       i_cfg_wdata,
    input  logic                    s_axis_tvalid,
    output logic                    s_axis_tready,
    // distance[15:0], now_time[47:16]
    input  logic [IN_TDATA_W-1:0]   s_axis_tdata,
    // kind[1:0]
    input  logic [KIND_W-1:0]       s_axis_tuser,
    output logic                    m_axis_tvalid,
    input  logic                    m_axis_tready,
    // estimate_valid[0], target_distance[16:1], closing_speed[32:17],
    // displacement[49:33], last_update_time[81:50], zero[87:82]
    output logic [OUT_TDATA_W-1:0]  m_axis_tdata
);

    localparam int OUT_PAD = OUT_TDATA_W - (1 + DIST_W + SPEED_W + DISP_W + TIME_W);

    function automatic logic [DIST_W-1:0] mid3(
        input logic [DIST_W-1:0] a,
        input logic [DIST_W-1:0] b,
        input logic [DIST_W-1:0] c
    );
        logic [DIST_W-1:0] lo;
        logic [DIST_W-1:0] hi;
        lo = (a > b) ? b : a;
        hi = (a > b) ? a : b;
        if (c >= hi) begin
            return hi;
        end else if (c <= lo) begin
            return lo;
        end
        return c;
    endfunction

    function automatic logic [QUO_W-1:0] times_1000(input logic [DIST_W-1:0] v);
        return {v, 10'b0} - {6'b0, v, 4'b0} - {7'b0, v, 3'b0};
    endfunction

    // configuration
    logic [DIST_W-1:0]  r_min_dist, r_max_dist;
    logic [OPB_W-1:0]   r_min_int, r_max_int, r_stale;
    logic [LIM_W-1:0]   r_max_speed, r_jump_marg, r_speed_lim;

    t_state             r_state, n_state;

    logic [KIND_W-1:0]  r_kind;
    logic [DIST_W-1:0]  r_dist;
    logic [TIME_W-1:0]  r_now;

    logic [DIST_W-1:0]  r_ring [3];
    logic [DIST_W-1:0]  n_ring [3];
    logic [1:0]         r_fill, n_fill;
    logic [1:0]         r_pos, n_pos;
    logic               r_has_ref, n_has_ref;
    logic [STEP_W-1:0]  r_steps, n_steps;
    logic [DIST_W-1:0]  r_ref, n_ref;
    logic [DIST_W-1:0]  r_prev, n_prev;
    logic signed [SPEED_W-1:0] r_smooth, n_smooth;
    logic [DIST_W-1:0]  r_med, n_med;
    logic signed [DISP_W-1:0]  r_delta, n_delta;
    logic [DIST_W-1:0]  r_mag, n_mag;

    logic               r_h_valid, n_h_valid;
    logic [DIST_W-1:0]  r_h_target, n_h_target;
    logic signed [SPEED_W-1:0] r_h_speed, n_h_speed;
    logic signed [DISP_W-1:0]  r_h_disp, n_h_disp;
    logic [TIME_W-1:0]  r_h_time, n_h_time;

    logic                   r_out_valid, n_out_valid;
    logic [OUT_TDATA_W-1:0] r_out_data, n_out_data;

    // serial unit
    t_su_ctrl           su_ctrl;
    t_su_stat           su_stat;
    logic [PROD_W-1:0]  su_product;
    logic [QUO_W-1:0]   su_quotient;

    // combinational helpers
    logic [TIME_W-1:0]  dt;
    logic               stale_over;
    logic               in_range;
    logic [DIST_W-1:0]  med;
    logic               too_soon, too_late;
    logic signed [DISP_W-1:0] delta_c, delta_neg;
    logic               over_marg;
    logic [DIST_W-1:0]  excess;
    logic               jump;
    logic               load_out;
    logic               do_restart;
    logic [DIST_W-1:0]  restart_dist;
    logic [STEP_W-1:0]  steps_inc;

    logic signed [QUO_W:0]   s_inst;
    logic signed [QUO_W+1:0] s_sm, s_sum, s_avg, s_pre, s_lim, s_clamp;

    assign dt         = r_now - r_h_time;
    assign stale_over = dt > {{(TIME_W-OPB_W){1'b0}}, r_stale};
    assign in_range   = (r_dist >= r_min_dist) && (r_dist <= r_max_dist);
    assign med        = mid3(r_ring[0], r_ring[1], r_ring[2]);
    assign too_soon   = (dt < {{(TIME_W-OPB_W){1'b0}}, r_min_int}) || (dt == '0);
    assign too_late   = dt > {{(TIME_W-OPB_W){1'b0}}, r_max_int};
    assign delta_c    = $signed({1'b0, r_prev} - {1'b0, med});
    assign delta_neg  = -delta_c;
    assign over_marg  = r_mag > {1'b0, r_jump_marg};
    assign excess     = r_mag - {1'b0, r_jump_marg};
    assign jump       = over_marg
                        && ({{(PROD_W-QUO_W){1'b0}}, times_1000(excess)} > su_product);
    assign load_out   = (r_state == ST_EMIT) && (!r_out_valid || m_axis_tready);
    assign steps_inc  = (r_steps == '1) ? r_steps : r_steps + 1'b1;

    // speed smoothing and clamp
    always_comb begin
        s_inst = r_delta[DISP_W-1] ? -$signed({1'b0, su_quotient})
                                   : $signed({1'b0, su_quotient});
        s_sm   = {{(QUO_W+2-SPEED_W){r_smooth[SPEED_W-1]}}, r_smooth};
        s_sum  = s_sm + s_sm + s_sm + {s_inst[QUO_W], s_inst};
        s_avg  = s_sum[QUO_W+1] ? ((s_sum + 28'sd3) >>> 2) : (s_sum >>> 2);
        s_pre  = (r_steps == '0) ? {s_inst[QUO_W], s_inst} : s_avg;
        s_lim  = $signed({{(QUO_W+2-LIM_W){1'b0}}, r_speed_lim});
        if (s_pre > s_lim) begin
            s_clamp = s_lim;
        end else if (s_pre < -s_lim) begin
            s_clamp = -s_lim;
        end else begin
            s_clamp = s_pre;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (s_axis_tvalid) begin
                    n_state = ST_EVAL;
                end
            end
            ST_EVAL: begin
                if (r_kind == KIND_SAMPLE && in_range && r_fill >= 2'd2) begin
                    n_state = ST_DECIDE;
                end else begin
                    n_state = ST_EMIT;
                end
            end
            ST_DECIDE: begin
                if (!r_has_ref || too_soon || too_late) begin
                    n_state = ST_EMIT;
                end else begin
                    n_state = ST_MUL;
                end
            end
            ST_MUL: begin
                if (su_stat.done) begin
                    n_state = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (jump) begin
                    n_state = ST_EMIT;
                end else begin
                    n_state = ST_DIV;
                end
            end
            ST_DIV: begin
                if (su_stat.done) begin
                    n_state = ST_SMOOTH;
                end
            end
            ST_SMOOTH: n_state = ST_EMIT;
            ST_EMIT: begin
                if (load_out) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // handshake and serial unit control
    always_comb begin
        s_axis_tready     = (r_state == ST_IDLE);
        su_ctrl.start_mul = (r_state == ST_DECIDE) && su_stat.idle && r_has_ref
                            && !too_soon && !too_late;
        su_ctrl.start_div = (r_state == ST_CHECK) && su_stat.idle && !jump;
    end

    // datapath
    always_comb begin
        n_ring      = r_ring;
        n_fill      = r_fill;
        n_pos       = r_pos;
        n_has_ref   = r_has_ref;
        n_steps     = r_steps;
        n_ref       = r_ref;
        n_prev      = r_prev;
        n_smooth    = r_smooth;
        n_med       = r_med;
        n_delta     = r_delta;
        n_mag       = r_mag;
        n_h_valid   = r_h_valid;
        n_h_target  = r_h_target;
        n_h_speed   = r_h_speed;
        n_h_disp    = r_h_disp;
        n_h_time    = r_h_time;
        do_restart  = 1'b0;
        restart_dist = med;
        case (r_state)
            ST_EVAL: begin
                case (r_kind)
                    KIND_SAMPLE: begin
                        if (in_range) begin
                            n_ring[r_pos] = r_dist;
                            n_pos  = (r_pos == 2'd2) ? 2'd0 : r_pos + 1'b1;
                            n_fill = (r_fill == 2'd3) ? r_fill : r_fill + 1'b1;
                        end else if (!r_has_ref || stale_over) begin
                            n_h_valid = 1'b0;
                        end
                    end
                    KIND_INVALID: begin
                        if (!r_has_ref || stale_over) begin
                            n_h_valid = 1'b0;
                        end
                    end
                    KIND_STALE: begin
                        if (r_has_ref && stale_over) begin
                            n_h_valid = 1'b0;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            ST_DECIDE: begin
                n_med   = med;
                n_delta = delta_c;
                n_mag   = delta_c[DISP_W-1] ? delta_neg[DIST_W-1:0] : delta_c[DIST_W-1:0];
                if (!r_has_ref || (!too_soon && too_late)) begin
                    do_restart = 1'b1;
                end
            end
            ST_CHECK: begin
                restart_dist = r_med;
                do_restart   = jump;
            end
            ST_SMOOTH: begin
                n_smooth   = s_clamp[SPEED_W-1:0];
                n_steps    = steps_inc;
                n_prev     = r_med;
                n_h_target = r_med;
                n_h_speed  = s_clamp[SPEED_W-1:0];
                n_h_disp   = $signed({1'b0, r_ref} - {1'b0, r_med});
                n_h_time   = r_now;
                n_h_valid  = (steps_inc >= 8'd2);
            end
            default: begin
            end
        endcase
        if (do_restart) begin
            n_ref      = restart_dist;
            n_prev     = restart_dist;
            n_smooth   = '0;
            n_steps    = '0;
            n_has_ref  = 1'b1;
            n_h_valid  = 1'b0;
            n_h_target = restart_dist;
            n_h_speed  = '0;
            n_h_disp   = '0;
            n_h_time   = r_now;
        end
    end

    // output register
    always_comb begin
        n_out_valid = r_out_valid;
        n_out_data  = r_out_data;
        if (load_out) begin
            n_out_valid = 1'b1;
            n_out_data  = {{OUT_PAD{1'b0}}, r_h_time, r_h_disp, r_h_speed,
                           r_h_target, r_h_valid};
        end else if (m_axis_tready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_dist  <= RST_MIN_DIST;
            r_max_dist  <= RST_MAX_DIST;
            r_min_int   <= RST_MIN_INT;
            r_max_int   <= RST_MAX_INT;
            r_stale     <= RST_STALE;
            r_max_speed <= RST_MAX_SPEED;
            r_jump_marg <= RST_JUMP_MARG;
            r_speed_lim <= RST_SPEED_LIM;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_MIN_DIST:  r_min_dist  <= i_cfg_wdata;
                CFG_MAX_DIST:  r_max_dist  <= i_cfg_wdata;
                CFG_MIN_INT:   r_min_int   <= i_cfg_wdata;
                CFG_MAX_INT:   r_max_int   <= i_cfg_wdata;
                CFG_STALE:     r_stale     <= i_cfg_wdata;
                CFG_MAX_SPEED: r_max_speed <= i_cfg_wdata[LIM_W-1:0];
                CFG_JUMP_MARG: r_jump_marg <= i_cfg_wdata[LIM_W-1:0];
                CFG_SPEED_LIM: r_speed_lim <= i_cfg_wdata[LIM_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_fill      <= '0;
            r_pos       <= '0;
            r_has_ref   <= 1'b0;
            r_steps     <= '0;
            r_h_valid   <= 1'b0;
            r_h_target  <= '0;
            r_h_speed   <= '0;
            r_h_disp    <= '0;
            r_h_time    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_fill      <= n_fill;
            r_pos       <= n_pos;
            r_has_ref   <= n_has_ref;
            r_steps     <= n_steps;
            r_h_valid   <= n_h_valid;
            r_h_target  <= n_h_target;
            r_h_speed   <= n_h_speed;
            r_h_disp    <= n_h_disp;
            r_h_time    <= n_h_time;
            r_out_valid <= n_out_valid;
        end
        if (r_state == ST_IDLE && s_axis_tvalid) begin
            r_kind <= s_axis_tuser;
            r_dist <= s_axis_tdata[DIST_W-1:0];
            r_now  <= s_axis_tdata[DIST_W +: TIME_W];
        end
        r_ring     <= n_ring;
        r_ref      <= n_ref;
        r_prev     <= n_prev;
        r_smooth   <= n_smooth;
        r_med      <= n_med;
        r_delta    <= n_delta;
        r_mag      <= n_mag;
        r_out_data <= n_out_data;
    end

    rme_serial_unit u_serial (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctrl     (su_ctrl),
        .i_mcand    (r_max_speed),
        .i_dividend (times_1000(r_mag)),
        .i_opb      (dt[OPB_W-1:0]),
        .o_stat     (su_stat),
        .o_product  (su_product),
        .o_quotient (su_quotient)
    );

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

endmodule

/* sv/rme_checker.sv */
// rme_checker: port-level checks of range_motion_estimator_core over time
// depends on rme_pkg; bound to the top level below
module rme_checker import rme_pkg::*; (
    input logic                    i_clk,
    input logic                    i_rst_n,
    input logic                    i_cfg_we,
    input logic [CFG_AW-1:0]       i_cfg_addr,
    input logic [CFG_DW-1:0]       i_cfg_wdata,
    input logic                    s_axis_tvalid,
    input logic                    s_axis_tready,
    input logic [IN_TDATA_W-1:0]   s_axis_tdata,
    input logic [KIND_W-1:0]       s_axis_tuser,
    input logic                    m_axis_tvalid,
    input logic                    m_axis_tready,
    input logic [OUT_TDATA_W-1:0]  m_axis_tdata
);

    // one word in flight at a time
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input accepted while a word is in flight");

    // stalled output word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output word changed while stalled");

    // a note or stale tick on an empty output gives its word via ST_EVAL and ST_EMIT
    a_short_path: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && s_axis_tuser != KIND_SAMPLE && !m_axis_tvalid
        |-> ##3 m_axis_tvalid)
        else $error("short-path word not delivered in time");

    // reset empties the output and opens the input
    a_reset_state: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid && s_axis_tready)
        else $error("bad state after reset");

endmodule

bind range_motion_estimator_core rme_checker u_rme_checker (.*);
